/* rtl/btpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_pkg: shared types and constants
// Word width, register indexes and sequencer step codes for the
// barometric compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int W     = 64;
  localparam int CNT_W = $clog2(W + 1);

  typedef logic [W-1:0] word_t;
  typedef logic [1:0]   cfg_idx_t;
  typedef logic [3:0]   step_t;

  localparam cfg_idx_t CFG_TEMP     = 2'd0;
  localparam cfg_idx_t CFG_PRESS_LO = 2'd1;
  localparam cfg_idx_t CFG_PRESS_HI = 2'd2;
  localparam cfg_idx_t CFG_PRESS_P9 = 2'd3;

  // temperature steps
  localparam step_t T_V1  = 4'd0;
  localparam step_t T_SQ  = 4'd1;
  localparam step_t T_V2  = 4'd2;
  localparam step_t T_FIN = 4'd3;

  // pressure steps
  localparam step_t P_SQ  = 4'd0;
  localparam step_t P_V2A = 4'd1;
  localparam step_t P_V2B = 4'd2;
  localparam step_t P_V1A = 4'd3;
  localparam step_t P_V1B = 4'd4;
  localparam step_t P_DEN = 4'd5;
  localparam step_t P_NUM = 4'd6;
  localparam step_t P_DIV = 4'd7;
  localparam step_t P_QQ  = 4'd8;
  localparam step_t P_V9  = 4'd9;
  localparam step_t P_V8  = 4'd10;
  localparam step_t P_FIN = 4'd11;

  localparam word_t T_OFS    = 64'd128000;
  localparam word_t ADC_FULL = 64'd1048576;
  localparam word_t P_SCALE  = 64'd3125;
  localparam word_t DEN_BIAS = 64'h0000_8000_0000_0000;
  localparam word_t T_ROUND  = 64'd128;

  localparam logic signed [W-1:0] TEMP_LO = -64'sd4000;
  localparam logic signed [W-1:0] TEMP_HI = 64'sd8500;

endpackage
`default_nettype wire

/* rtl/baro_temp_pressure_compensation.sv */
`timescale 1ns / 1ps
`default_nettype none
// A temperature item takes three multiplies; a pressure item takes ten multiplies
// plus a divide, all on the bit-serial multiplier and divider.
// Items are handled one at a time; a new sample is accepted only when idle.
// The output register lets the next item enter while a result waits.
// Reset (synchronous, rst_n low) clears calibration, fine temperature and control.
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation: barometer compensation top level
// Step sequencer around a shared bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire [23:0]          in_tdata,   // [19:0] raw_adc
  input  wire                 in_tuser,   // [0] func
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [47:0]         out_tdata,  // [14:0] temp_centideg, [46:15] pressure_q24_8,
                                          // [47] div_zero
  output logic                out_tuser,  // [0] is_pressure
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire btpc_pkg::cfg_idx_t cfg_index,
  input  wire [63:0]          cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  btpc_pkg::step_t     step_r, step_nxt;
  logic                func_r, func_nxt;
  logic [19:0]         adc_r, adc_nxt;
  btpc_pkg::word_t     v_r, v_nxt, w_r, w_nxt, x_r, x_nxt, y_r, y_nxt;
  logic [31:0]         fine_r, fine_nxt;
  logic [47:0]         tcal_r;
  logic [63:0]         plo_r, phi_r;
  logic [15:0]         p9_r;
  logic [14:0]         res_temp_r, res_temp_nxt;
  logic [31:0]         res_press_r, res_press_nxt;
  logic                res_dz_r, res_dz_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [47:0]         out_data_r;
  logic                out_user_r;
  logic                out_load;
  logic                in_acc;

  logic                mul_start, mul_busy, mul_done;
  btpc_pkg::word_t     mul_a, mul_b, mul_p;
  logic                div_start, div_done;
  btpc_pkg::word_t     div_q;

  btpc_pkg::word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  btpc_pkg::word_t adc64, da, db, num, den_in, qv, tsum, tval, psum, den_new;

  btpc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_p)
  );

  btpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (y_r),
    .den   (x_r),
    .done  (div_done),
    .quo   (div_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    t1 = 64'(tcal_r[15:0]);
    t2 = 64'($signed(tcal_r[31:16]));
    t3 = 64'($signed(tcal_r[47:32]));
    p1 = 64'(plo_r[15:0]);
    p2 = 64'($signed(plo_r[31:16]));
    p3 = 64'($signed(plo_r[47:32]));
    p4 = 64'($signed(plo_r[63:48]));
    p5 = 64'($signed(phi_r[15:0]));
    p6 = 64'($signed(phi_r[31:16]));
    p7 = 64'($signed(phi_r[47:32]));
    p8 = 64'($signed(phi_r[63:48]));
    p9 = 64'($signed(p9_r));
    adc64   = 64'(adc_r);
    da      = (adc64 >> 3) - (t1 << 1);
    db      = (adc64 >> 4) - t1;
    num     = ((btpc_pkg::ADC_FULL - adc64) << 31) - y_r;
    den_in  = x_r + btpc_pkg::DEN_BIAS;
    qv      = 64'($signed(v_r) >>> 13);
    tsum    = (x_r << 2) + x_r + btpc_pkg::T_ROUND;
    tval    = 64'($signed(tsum) >>> 8);
    psum    = 64'($signed(v_r + x_r + y_r) >>> 8) + (p7 << 4);
    den_new = 64'($signed(mul_p) >>> 33);
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    func_nxt      = func_r;
    adc_nxt       = adc_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    fine_nxt      = fine_r;
    res_temp_nxt  = res_temp_r;
    res_press_nxt = res_press_r;
    res_dz_nxt    = res_dz_r;
    mul_start     = 1'b0;
    mul_a         = v_r;
    mul_b         = v_r;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt  = in_tuser;
          adc_nxt   = in_tdata[19:0];
          v_nxt     = 64'($signed(fine_r)) - btpc_pkg::T_OFS;
          step_nxt  = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        state_nxt = S_MUL;
        mul_start = 1'b1;
        if (!func_r) begin
          case (step_r)
            btpc_pkg::T_V1: begin mul_a = da;  mul_b = t2; end
            btpc_pkg::T_SQ: begin mul_a = db;  mul_b = db; end
            btpc_pkg::T_V2: begin mul_a = y_r; mul_b = t3; end
            default: begin
              mul_start     = 1'b0;
              fine_nxt      = x_r[31:0];
              res_press_nxt = '0;
              res_dz_nxt    = 1'b0;
              if ($signed(tval) < btpc_pkg::TEMP_LO)
                res_temp_nxt = btpc_pkg::TEMP_LO[14:0];
              else if ($signed(tval) > btpc_pkg::TEMP_HI)
                res_temp_nxt = btpc_pkg::TEMP_HI[14:0];
              else
                res_temp_nxt = tval[14:0];
              state_nxt = S_OUT;
            end
          endcase
        end else begin
          case (step_r)
            btpc_pkg::P_SQ:  begin mul_a = v_r;    mul_b = v_r; end
            btpc_pkg::P_V2A: begin mul_a = w_r;    mul_b = p6; end
            btpc_pkg::P_V2B: begin mul_a = v_r;    mul_b = p5; end
            btpc_pkg::P_V1A: begin mul_a = w_r;    mul_b = p3; end
            btpc_pkg::P_V1B: begin mul_a = v_r;    mul_b = p2; end
            btpc_pkg::P_DEN: begin mul_a = den_in; mul_b = p1; end
            btpc_pkg::P_NUM: begin mul_a = num;    mul_b = btpc_pkg::P_SCALE; end
            btpc_pkg::P_DIV: begin
              mul_start = 1'b0;
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
            btpc_pkg::P_QQ:  begin mul_a = qv;     mul_b = qv; end
            btpc_pkg::P_V9:  begin mul_a = w_r;    mul_b = p9; end
            btpc_pkg::P_V8:  begin mul_a = v_r;    mul_b = p8; end
            default: begin
              mul_start    = 1'b0;
              res_temp_nxt = '0;
              res_dz_nxt   = 1'b0;
              if (psum[63])
                res_press_nxt = '0;
              else if (psum[63:32] != '0)
                res_press_nxt = '1;
              else
                res_press_nxt = psum[31:0];
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_MUL: begin
        if (mul_done) begin
          step_nxt  = step_r + 1'b1;
          state_nxt = S_ISSUE;
          if (!func_r) begin
            case (step_r)
              btpc_pkg::T_V1: x_nxt = 64'($signed(mul_p) >>> 11);
              btpc_pkg::T_SQ: y_nxt = 64'($signed(mul_p) >>> 12);
              default:        x_nxt = x_r + 64'($signed(mul_p) >>> 14);
            endcase
          end else begin
            case (step_r)
              btpc_pkg::P_SQ:  w_nxt = mul_p;
              btpc_pkg::P_V2A: y_nxt = mul_p;
              btpc_pkg::P_V2B: y_nxt = y_r + (mul_p << 17) + (p4 << 35);
              btpc_pkg::P_V1A: x_nxt = 64'($signed(mul_p) >>> 8);
              btpc_pkg::P_V1B: x_nxt = x_r + (mul_p << 12);
              btpc_pkg::P_DEN: begin
                x_nxt = den_new;
                if (den_new == '0) begin
                  res_temp_nxt  = '0;
                  res_press_nxt = '0;
                  res_dz_nxt    = 1'b1;
                  state_nxt     = S_OUT;
                end
              end
              btpc_pkg::P_NUM: y_nxt = mul_p;
              btpc_pkg::P_QQ:  w_nxt = mul_p;
              btpc_pkg::P_V9:  x_nxt = 64'($signed(mul_p) >>> 25);
              default:         y_nxt = 64'($signed(mul_p) >>> 19);
            endcase
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          v_nxt     = div_q;
          step_nxt  = step_r + 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fine_r      <= '0;
      tcal_r      <= '0;
      plo_r       <= '0;
      phi_r       <= '0;
      p9_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fine_r      <= fine_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          btpc_pkg::CFG_TEMP:     tcal_r <= cfg_data[47:0];
          btpc_pkg::CFG_PRESS_LO: plo_r  <= cfg_data;
          btpc_pkg::CFG_PRESS_HI: phi_r  <= cfg_data;
          btpc_pkg::CFG_PRESS_P9: p9_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
    step_r      <= step_nxt;
    func_r      <= func_nxt;
    adc_r       <= adc_nxt;
    v_r         <= v_nxt;
    w_r         <= w_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    res_temp_r  <= res_temp_nxt;
    res_press_r <= res_press_nxt;
    res_dz_r    <= res_dz_nxt;
    if (out_load) begin
      out_data_r <= {res_dz_r, res_press_r, res_temp_r};
      out_user_r <= func_r;
    end
  end

  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy) else $error("multiplier restarted while busy");

  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (x_r != '0)) else $error("divide issued with zero divisor");

  a_step_clr: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (step_r == '0) && (state_r == S_ISSUE)) else $error("item start not clean");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[47]) |-> (out_user_r && (out_data_r[46:0] == '0)))
    else $error("divide-by-zero result not cleared");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == S_OUT)) else $error("output loaded outside output state");

endmodule
`default_nettype wire

/* rtl/btpc_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_mul: bit-serial multiplier
// Shift-and-add, one multiplier bit per cycle, product modulo 2^64.
// Stops as soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module btpc_mul (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire btpc_pkg::word_t a,
  input  wire btpc_pkg::word_t b,
  output logic                busy,
  output logic                done,
  output btpc_pkg::word_t     prod
);

  btpc_pkg::word_t a_r, a_nxt;
  btpc_pkg::word_t b_r, b_nxt;
  btpc_pkg::word_t acc_r, acc_nxt;
  logic            busy_r, busy_nxt;

  assign busy = busy_r;
  assign done = busy_r && (b_r == '0);
  assign prod = acc_r;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    busy_nxt = busy_r;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (b_r[0]) acc_nxt = acc_r + a_r;
        a_nxt = {a_r[btpc_pkg::W-2:0], 1'b0};
        b_nxt = {1'b0, b_r[btpc_pkg::W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

endmodule
`default_nettype wire

/* rtl/btpc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_div: bit-serial signed divider
// Restoring division on magnitudes, one quotient bit per cycle,
// quotient truncated toward zero. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module btpc_div (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire btpc_pkg::word_t num,
  input  wire btpc_pkg::word_t den,
  output logic                done,
  output btpc_pkg::word_t     quo
);

  btpc_pkg::word_t                 rem_r, rem_nxt;
  btpc_pkg::word_t                 quo_r, quo_nxt;
  btpc_pkg::word_t                 dvs_r, dvs_nxt;
  logic [btpc_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            neg_r, neg_nxt;
  logic                            busy_r, busy_nxt;
  logic [btpc_pkg::W:0]            sh;

  assign done = busy_r && (cnt_r == btpc_pkg::CNT_W'(btpc_pkg::W));
  assign quo  = neg_r ? (~quo_r + 1'b1) : quo_r;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    sh       = {rem_r, quo_r[btpc_pkg::W-1]};
    if (start) begin
      neg_nxt  = num[btpc_pkg::W-1] ^ den[btpc_pkg::W-1];
      quo_nxt  = num[btpc_pkg::W-1] ? (~num + 1'b1) : num;
      dvs_nxt  = den[btpc_pkg::W-1] ? (~den + 1'b1) : den;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = btpc_pkg::W'(sh - {1'b0, dvs_r});
        quo_nxt = {quo_r[btpc_pkg::W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[btpc_pkg::W-1:0];
        quo_nxt = {quo_r[btpc_pkg::W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

endmodule
`default_nettype wire

/* tb/baro_comp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_comp_checker: result predictor and scoreboard
// Watches the config, input and result channels of the barometric
// compensation block, computes each expected result in 64-bit integer
// arithmetic and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module baro_comp_checker (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  input  wire                     in_tready,
  input  wire [23:0]              in_tdata,
  input  wire                     in_tuser,
  input  wire                     out_tvalid,
  input  wire                     out_tready,
  input  wire [47:0]              out_tdata,
  input  wire                     out_tuser,
  input  wire                     cfg_valid,
  input  wire                     cfg_ready,
  input  wire btpc_pkg::cfg_idx_t cfg_index,
  input  wire [63:0]              cfg_data,
  output int                      fail_count,
  output int                      pending_count
);

  typedef struct packed {
    logic        is_pressure;
    logic [14:0] temp_centideg;
    logic [31:0] pressure_q24_8;
    logic        div_zero;
  } comp_result_t;

  logic [47:0] t_cal;
  logic [63:0] p_cal_lo, p_cal_hi;
  logic [15:0] p_cal_nine;
  logic [31:0] t_fine;
  comp_result_t expected_q[$];

  function automatic logic signed [63:0] sx16(logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic comp_result_t compensate_temp(logic [19:0] adc);
    logic signed [63:0] t1, t2, t3, a, b, v1, v2, tf, t;
    comp_result_t r;
    t1 = {48'd0, t_cal[15:0]};
    t2 = sx16(t_cal[31:16]);
    t3 = sx16(t_cal[47:32]);
    a  = (64'(adc) >> 3) - (t1 <<< 1);
    b  = (64'(adc) >> 4) - t1;
    v1 = (a * t2) >>> 11;
    v2 = (((b * b) >>> 12) * t3) >>> 14;
    tf = v1 + v2;
    t  = (tf * 5 + 128) >>> 8;
    t_fine = tf[31:0];
    if (t < -4000) t = -4000;
    else if (t > 8500) t = 8500;
    r = '0;
    r.temp_centideg = t[14:0];
    return r;
  endfunction

  function automatic comp_result_t compensate_press(logic [19:0] adc);
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, tf, v1, v2, p, q, num;
    logic [63:0] mn, md, mq;
    comp_result_t r;
    r = '0;
    r.is_pressure = 1'b1;
    p1 = {48'd0, p_cal_lo[15:0]};
    p2 = sx16(p_cal_lo[31:16]);
    p3 = sx16(p_cal_lo[47:32]);
    p4 = sx16(p_cal_lo[63:48]);
    p5 = sx16(p_cal_hi[15:0]);
    p6 = sx16(p_cal_hi[31:16]);
    p7 = sx16(p_cal_hi[47:32]);
    p8 = sx16(p_cal_hi[63:48]);
    p9 = sx16(p_cal_nine);
    tf = {{32{t_fine[31]}}, t_fine};
    v1 = tf - 128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) begin
      r.div_zero = 1'b1;
      return r;
    end
    p   = 1048576 - 64'(adc);
    num = ((p <<< 31) - v2) * 3125;
    mn  = num[63] ? -num : num;
    md  = v1[63] ? -v1 : v1;
    mq  = mn / md;
    p   = (num[63] != v1[63]) ? -mq : mq;
    q   = p >>> 13;
    v1  = (p9 * q * q) >>> 25;
    v2  = (p8 * p) >>> 19;
    p   = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
    if (p < 0) r.pressure_q24_8 = '0;
    else if (p > 64'sh0_FFFF_FFFF) r.pressure_q24_8 = '1;
    else r.pressure_q24_8 = p[31:0];
    return r;
  endfunction

  assign pending_count = expected_q.size();

  always @(posedge clk) begin
    comp_result_t got, want;
    if (!rst_n) begin
      t_cal <= '0; p_cal_lo <= '0; p_cal_hi <= '0; p_cal_nine <= '0; t_fine = '0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          btpc_pkg::CFG_TEMP:     t_cal <= cfg_data[47:0];
          btpc_pkg::CFG_PRESS_LO: p_cal_lo <= cfg_data;
          btpc_pkg::CFG_PRESS_HI: p_cal_hi <= cfg_data;
          btpc_pkg::CFG_PRESS_P9: p_cal_nine <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) expected_q.push_back(compensate_press(in_tdata[19:0]));
        else expected_q.push_back(compensate_temp(in_tdata[19:0]));
      end
      if (out_tvalid && out_tready) begin
        got.is_pressure    = out_tuser;
        got.temp_centideg  = out_tdata[14:0];
        got.pressure_q24_8 = out_tdata[46:15];
        got.div_zero       = out_tdata[47];
        if (expected_q.size() == 0) begin
          $error("unexpected result item: tdata %h tuser %b", out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got != want) fail_count <= fail_count + 1;
          if (got.is_pressure != want.is_pressure)
            $error("is_pressure: expected %0d actual %0d", want.is_pressure, got.is_pressure);
          if (got.temp_centideg != want.temp_centideg)
            $error("temp_centideg: expected %0d actual %0d",
                   $signed(want.temp_centideg), $signed(got.temp_centideg));
          if (got.pressure_q24_8 != want.pressure_q24_8)
            $error("pressure_q24_8: expected %0d actual %0d",
                   want.pressure_q24_8, got.pressure_q24_8);
          if (got.div_zero != want.div_zero)
            $error("div_zero: expected %0d actual %0d", want.div_zero, got.div_zero);
        end
      end
    end
  end
endmodule

/* tb/tb_baro_temp_pressure_compensation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_baro_temp_pressure_compensation: barometric compensation testbench
// Drives calibration phases and temperature/pressure samples with random
// gaps and back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_baro_temp_pressure_compensation;

  localparam int WATCHDOG = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  btpc_pkg::cfg_idx_t cfg_index = btpc_pkg::CFG_TEMP;
  logic [63:0] cfg_data = '0;
  int          fail_count, pending_count;
  bit          hold_rx = 1'b0;
  int          idle_cycles = 0;

  always #1 clk = ~clk;

  baro_temp_pressure_compensation uut (.*);

  baro_comp_checker checker_i (.*);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  // result side back-pressure
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) out_tready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        g = gap_len() + 1;
        repeat (g) @(negedge clk);
        out_tready <= 1'b1;
      end else out_tready <= 1'b1;
    end
  end

  task automatic write_reg(btpc_pkg::cfg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // leaves in_tvalid high so items can follow back to back
  task automatic send_sample(bit is_press, logic [19:0] adc, bit gaps);
    int g;
    if (gaps) begin
      g = gap_len();
      if (g != 0) begin
        in_tvalid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_press;
    in_tdata  <= {4'd0, adc};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (900) @(negedge clk);
  endtask

  // typical sensor calibration with mild spread
  task automatic load_typical();
    logic [15:0] t1, p1;
    t1 = 16'd27504 + 16'($urandom_range(0, 2000)) - 16'd1000;
    p1 = 16'd36477 + 16'($urandom_range(0, 4000)) - 16'd2000;
    write_reg(btpc_pkg::CFG_TEMP, {16'hFF9C + 16'($urandom_range(0, 200)), 16'd26435, t1});
    write_reg(btpc_pkg::CFG_PRESS_LO, {16'd2855, 16'd3024, -16'sd10685, p1});
    write_reg(btpc_pkg::CFG_PRESS_HI, {-16'sd12000 + 16'($urandom_range(0, 24000)),
                                       16'd15500, -16'sd7, 16'd140});
    write_reg(btpc_pkg::CFG_PRESS_P9, 16'd6000 + 16'($urandom_range(0, 1000)));
  endtask

  task automatic load_random();
    write_reg(btpc_pkg::CFG_TEMP, {$urandom, $urandom});
    write_reg(btpc_pkg::CFG_PRESS_LO, {$urandom, $urandom});
    write_reg(btpc_pkg::CFG_PRESS_HI, {$urandom, $urandom});
    write_reg(btpc_pkg::CFG_PRESS_P9, {$urandom, $urandom});
  endtask

  task automatic random_burst(int n);
    repeat (n)
      send_sample($urandom_range(0, 1), ($urandom_range(0, 3) == 0) ? 20'($urandom) :
                  20'd400000 + 20'($urandom_range(0, 300000)), 1'b1);
  endtask

  initial begin
    int hold;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pressure before any temperature, all-zero calibration (zero divisor)
    send_sample(1'b1, 20'd415148, 1'b0);
    send_sample(1'b0, 20'd519888, 1'b0);
    drain();

    load_typical();
    send_sample(1'b1, 20'd0, 1'b0);
    send_sample(1'b0, 20'd519888, 1'b0);
    send_sample(1'b1, 20'd415148, 1'b0);
    send_sample(1'b1, 20'hFFFFF, 1'b0);
    send_sample(1'b0, 20'd0, 1'b0);
    send_sample(1'b0, 20'hFFFFF, 1'b0);
    send_sample(1'b1, 20'd0, 1'b0);
    drain();

    // extreme calibration words
    write_reg(btpc_pkg::CFG_TEMP, 48'hFFFF_FFFF_FFFF);
    write_reg(btpc_pkg::CFG_PRESS_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(btpc_pkg::CFG_PRESS_HI, 64'h7FFF_8000_7FFF_8000);
    write_reg(btpc_pkg::CFG_PRESS_P9, 64'h8000);
    send_sample(1'b0, 20'hFFFFF, 1'b0);
    send_sample(1'b1, 20'd0, 1'b0);
    send_sample(1'b0, 20'd0, 1'b0);
    send_sample(1'b1, 20'hFFFFF, 1'b0);
    drain();
    write_reg(btpc_pkg::CFG_TEMP, 48'h7FFF_7FFF_0000);
    write_reg(btpc_pkg::CFG_PRESS_LO, 64'h8000_8000_8000_0001);
    write_reg(btpc_pkg::CFG_PRESS_HI, 64'h8000_7FFF_8000_7FFF);
    write_reg(btpc_pkg::CFG_PRESS_P9, 64'h7FFF);
    send_sample(1'b0, 20'h55555, 1'b0);
    send_sample(1'b1, 20'hAAAAA, 1'b0);
    send_sample(1'b1, 20'h55555, 1'b0);
    drain();

    // long receiver hold-off while samples keep coming
    load_typical();
    hold_rx = 1'b1;
    fork
      begin
        hold = 3000;
        repeat (hold) @(negedge clk);
        hold_rx = 1'b0;
      end
      random_burst(8);
    join
    drain();

    repeat (8) begin
      if ($urandom_range(0, 3) == 0) load_random();
      else load_typical();
      random_burst(140);
      drain();
    end

    drain();
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

/* files.f */
rtl/btpc_pkg.sv
rtl/btpc_mul.sv
rtl/btpc_div.sv
rtl/baro_temp_pressure_compensation.sv
tb/baro_comp_checker.sv
tb/tb_baro_temp_pressure_compensation.sv
